// ===== rtl/core/rss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the record selection sorter.
package rss_pkg;

    localparam int SURNAME_HEAD_W  = 64;
    localparam int SURNAME_TAIL_W  = 8;
    localparam int GIVEN_HEAD_W    = 64;
    localparam int GIVEN_TAIL_W    = 8;
    localparam int REC_W           = SURNAME_HEAD_W + SURNAME_TAIL_W
                                   + GIVEN_HEAD_W + GIVEN_TAIL_W;
    localparam int MAX_RECORDS_DEF = 16;

    // Field order puts the most significant key first, so the packed
    // record compares as one unsigned vector in key order.
    typedef struct packed {
        logic [SURNAME_HEAD_W-1:0] surname_head;
        logic [SURNAME_TAIL_W-1:0] surname_tail;
        logic [GIVEN_HEAD_W-1:0]   given_head;
        logic [GIVEN_TAIL_W-1:0]   given_tail;
    } rec_t;

endpackage

// ===== rtl/core/rss_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rss_ram #(
    parameter int WIDTH = rss_pkg::REC_W,
    parameter int DEPTH = rss_pkg::MAX_RECORDS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rss_cmp.sv =====
`timescale 1ns / 1ps
// Key comparator: surname then given name, byte-wise unsigned.
module rss_cmp (
    input  rss_pkg::rec_t cand,
    input  rss_pkg::rec_t best,
    output logic          less
);

    logic [rss_pkg::SURNAME_HEAD_W+rss_pkg::SURNAME_TAIL_W-1:0] cand_sur;
    logic [rss_pkg::SURNAME_HEAD_W+rss_pkg::SURNAME_TAIL_W-1:0] best_sur;
    logic [rss_pkg::GIVEN_HEAD_W+rss_pkg::GIVEN_TAIL_W-1:0]     cand_giv;
    logic [rss_pkg::GIVEN_HEAD_W+rss_pkg::GIVEN_TAIL_W-1:0]     best_giv;

    assign cand_sur = {cand.surname_head, cand.surname_tail};
    assign best_sur = {best.surname_head, best.surname_tail};
    assign cand_giv = {cand.given_head, cand.given_tail};
    assign best_giv = {best.given_head, best.given_tail};

    // Strictly less, so the earlier record wins on a tie.
    always_comb
    begin
        if (cand_sur != best_sur)
        begin
            less = (cand_sur < best_sur);
        end
        else
        begin
            less = (cand_giv < best_giv);
        end
    end

endmodule

// ===== rtl/core/record_selection_sorter.sv =====
`timescale 1ns / 1ps
// Top level: record store, selection-sort sequencer and result output.
//
// Records load one per cycle while busy is low. A record with last_record set
// closes the set: busy rises and the block selection-sorts the stored records
// (at most MAX_RECORDS; records beyond that are dropped) by surname, then given
// name, and strobes each sorted record out on out_valid for exactly one cycle,
// smallest first, with final_out on the last one. The receiver cannot stall the
// output. Pass i reads record i and then scans the remaining records through
// the single read port of the record RAM, one record compared per cycle;
// results come one per pass. Stored records need no clearing pass after reset.
module record_selection_sorter #(
    parameter int MAX_RECORDS = rss_pkg::MAX_RECORDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rss_pkg::SURNAME_HEAD_W-1:0] surname_head,
    input  logic [rss_pkg::SURNAME_TAIL_W-1:0] surname_tail,
    input  logic [rss_pkg::GIVEN_HEAD_W-1:0]   given_head,
    input  logic [rss_pkg::GIVEN_TAIL_W-1:0]   given_tail,
    input  logic                              last_record,
    output logic                              out_valid,
    output logic [rss_pkg::SURNAME_HEAD_W-1:0] sorted_surname_head,
    output logic [rss_pkg::SURNAME_TAIL_W-1:0] sorted_surname_tail,
    output logic [rss_pkg::GIVEN_HEAD_W-1:0]   sorted_given_head,
    output logic [rss_pkg::GIVEN_TAIL_W-1:0]   sorted_given_tail,
    output logic                              final_out
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RDI  = 5'b00010,
        ST_LDI  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_SWAP = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  m_reg, m_next;
    rss_pkg::rec_t     cur_reg, cur_next;
    rss_pkg::rec_t     min_reg, min_next;
    logic              ov_reg, ov_next;
    logic              fin_reg, fin_next;
    rss_pkg::rec_t     out_reg, out_next;

    rss_pkg::rec_t     in_rec;
    rss_pkg::rec_t     rd_rec;
    logic              accept;
    logic              full;
    logic              less;
    logic [CNT_W-1:0]  i_plus1;
    logic [CNT_W-1:0]  j_plus1;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [rss_pkg::REC_W-1:0] ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [rss_pkg::REC_W-1:0] ram_rdata;

    assign in_rec.surname_head = surname_head;
    assign in_rec.surname_tail = surname_tail;
    assign in_rec.given_head   = given_head;
    assign in_rec.given_tail   = given_tail;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign full    = (cnt_reg >= CNT_W'(MAX_RECORDS));
    assign i_plus1 = CNT_W'(i_reg) + CNT_W'(1);
    assign j_plus1 = CNT_W'(j_reg) + CNT_W'(1);
    assign rd_rec  = rss_pkg::rec_t'(ram_rdata);

    rss_ram #(
        .WIDTH (rss_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rss_cmp u_cmp (
        .cand (rd_rec),
        .best (min_reg),
        .less (less)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        cur_next   = cur_reg;
        min_next   = min_reg;
        ov_next    = 1'b0;
        fin_next   = 1'b0;
        out_next   = out_reg;
        ram_we     = 1'b0;
        ram_waddr  = m_reg;
        ram_wdata  = cur_reg;
        ram_re     = 1'b0;
        ram_raddr  = i_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Drop the beat when the store is full, but still honour last_record.
                    if (!full)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[IDX_W-1:0];
                        ram_wdata = in_rec;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    if (last_record)
                    begin
                        n_next     = full ? cnt_reg : (cnt_reg + CNT_W'(1));
                        i_next     = '0;
                        state_next = ST_RDI;
                    end
                end
            end
            ST_RDI:
            begin
                ram_re     = 1'b1;
                ram_raddr  = i_reg;
                state_next = ST_LDI;
            end
            ST_LDI:
            begin
                cur_next = rd_rec;
                min_next = rd_rec;
                m_next   = i_reg;
                if (i_plus1 < n_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_plus1[IDX_W-1:0];
                    j_next     = i_plus1[IDX_W-1:0];
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SCAN:
            begin
                // Compare the record read last cycle while fetching the next one.
                if (less)
                begin
                    min_next = rd_rec;
                    m_next   = j_reg;
                end
                if (j_plus1 < n_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_plus1[IDX_W-1:0];
                    j_next     = j_plus1[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                // Slot i is final now: emit the minimum, move the displaced record.
                ram_we    = (m_reg != i_reg);
                ram_waddr = m_reg;
                ram_wdata = cur_reg;
                ov_next   = 1'b1;
                out_next  = min_reg;
                if (i_plus1 < n_reg)
                begin
                    i_next     = i_plus1[IDX_W-1:0];
                    state_next = ST_RDI;
                end
                else
                begin
                    fin_next   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            m_reg     <= '0;
            ov_reg    <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            ov_reg    <= ov_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        min_reg <= min_next;
        out_reg <= out_next;
    end

    assign out_valid           = ov_reg;
    assign final_out           = fin_reg;
    assign sorted_surname_head = out_reg.surname_head;
    assign sorted_surname_tail = out_reg.surname_tail;
    assign sorted_given_head   = out_reg.given_head;
    assign sorted_given_tail   = out_reg.given_tail;

    a_final_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        final_out |-> out_valid)
        else $error("final_out without out_valid");

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_record) |=> busy)
        else $error("closing record did not start the sort");

    a_idle_strobe_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy) |-> final_out)
        else $error("non-final result while idle");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

endmodule
